// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low.
`define RSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsm assertion failed");

// Clocked assertion that also holds during reset.
`define RSM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rsm assertion failed");

`endif

// ----- rtl/rsm_pkg.sv -----
// Types, constants and helper functions of the tapered box mask.
package rsm_pkg;

    localparam int COORD_W    = 12;
    localparam int FRAC_W     = 8;
    localparam int DIST_W     = COORD_W + FRAC_W;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int NAX        = 3;
    localparam int Q_W        = 17;
    localparam int DIV_N      = Q_W;
    localparam int PIPE_N     = DIV_N + 11;
    localparam int RESULT_LAT = PIPE_N + 3;

    localparam int MODE_INV_BIT = 0;
    localparam int MODE_MSK_BIT = 1;

    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [16:0] U_MAX    = 17'd65536;

    localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
    localparam logic signed [31:0] SIN_C3 = -32'sd693598668;
    localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
    localparam logic signed [31:0] SIN_C7 = -32'sd5026995;
    localparam logic signed [31:0] SIN_C9 = 32'sd172273;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_Z, REG_CENTER_Y, REG_CENTER_X,
        REG_RADIUS_Z, REG_RADIUS_Y, REG_RADIUS_X,
        REG_TAPER, REG_MODE
    } t_reg_idx;

    typedef enum logic [1:0] {CLS_ZERO, CLS_ONE, CLS_TAPER} t_cls;

    typedef struct packed {
        logic [COORD_W-1:0] coord_z;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_x;
        logic signed [15:0] sample_in;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [15:0]        mask_value;
    } t_out;

    // axis 0 is z, 1 is y, 2 is x
    typedef struct packed {
        logic [NAX-1:0][CFG_W-1:0] center;
        logic [NAX-1:0][CFG_W-1:0] radius;
        logic [CFG_W-1:0]          taper;
        logic [1:0]                mode;
    } t_cfg;

    typedef struct packed {
        t_cls                      cls;
        logic [NAX-1:0]            act;
        logic [NAX-1:0][DIST_W-1:0] ex;
        logic signed [15:0]        sample;
    } t_item;

    typedef struct packed {
        t_cls               cls;
        logic [NAX-1:0]     act;
        logic signed [15:0] sample;
    } t_car;

    typedef struct packed {
        logic [CFG_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   q;
    } t_dstep;

    // one restoring division step
    function automatic t_dstep div_step(input t_dstep s, input logic [CFG_W-1:0] t);
        t_dstep o;
        logic [CFG_W:0] tmp;
        tmp   = {s.rem, s.low[Q_W-1]};
        o.low = {s.low[Q_W-2:0], 1'b0};
        if (tmp >= {1'b0, t}) begin
            o.rem = CFG_W'(tmp - {1'b0, t});
            o.q   = {s.q[Q_W-2:0], 1'b1};
        end else begin
            o.rem = tmp[CFG_W-1:0];
            o.q   = {s.q[Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ----- rtl/rsm_front.sv -----
// Front end: takes requests, measures axis distances, classifies the voxel.
module rsm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rsm_pkg::t_in  i_item,
    input  rsm_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_busy,
    output logic          o_push,
    output rsm_pkg::t_item o_item
);
    import rsm_pkg::*;

    logic  r_run;
    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_busy = !r_run || (r_vld && i_full);
    assign accept = i_start && !o_busy;
    assign o_push = r_vld && !i_full;
    assign o_item = r_item;

    always_comb begin
        logic [NAX-1:0][COORD_W-1:0] crd;
        logic [DIST_W-1:0] c;
        logic [DIST_W-1:0] d;
        logic [NAX-1:0]    outs;
        crd = {i_item.coord_x, i_item.coord_y, i_item.coord_z};
        n_item = '0;
        outs   = '0;
        for (int a = 0; a < NAX; a++) begin
            c = {crd[a], FRAC_W'(0)};
            d = (c >= i_cfg.center[a]) ? c - i_cfg.center[a] : i_cfg.center[a] - c;
            n_item.act[a] = d > i_cfg.radius[a];
            outs[a]       = {1'b0, d} > ({1'b0, i_cfg.radius[a]} + {1'b0, i_cfg.taper});
            n_item.ex[a]  = d - i_cfg.radius[a];
        end
        n_item.sample = i_item.sample_in;
        if (i_cfg.taper == '0) begin
            n_item.cls = (n_item.act == '0) ? CLS_ONE : CLS_ZERO;
        end else if (outs != '0) begin
            n_item.cls = CLS_ZERO;
        end else if (n_item.act == '0) begin
            n_item.cls = CLS_ONE;
        end else begin
            n_item.cls = CLS_TAPER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (accept) begin
                r_vld <= 1'b1;
            end else if (!i_full) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/rsm_queue.sv -----
// Two-entry queue between front and back.
module rsm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rsm_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_vld,
    output rsm_pkg::t_item o_head
);
    import rsm_pkg::*;

    t_item      r_q [2];
    logic [1:0] r_cnt;
    logic       pop;

    assign o_full = r_cnt == 2'd2;
    assign o_vld  = r_cnt != 2'd0;
    assign o_head = r_q[0];
    assign pop    = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_q[0] <= i_item;
        end else if (pop && r_cnt == 2'd2) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && r_cnt == 2'd1 && !pop) begin
            r_q[1] <= i_item;
        end
    end

endmodule

// ----- rtl/rsm_back.sv -----
// Back end: divider, cosine polynomial, mask product and output scaling.
module rsm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  rsm_pkg::t_item   i_item,
    input  logic [rsm_pkg::CFG_W-1:0] i_taper,
    input  logic [1:0]       i_mode,
    output logic             o_pop,
    output logic             o_strobe,
    output rsm_pkg::t_out    o_result
);
    import rsm_pkg::*;

    localparam logic signed [31:0] COEF [4] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

    t_dstep             r_ds [DIV_N][NAX];
    t_dstep             n_ds [DIV_N][NAX];
    logic signed [17:0] r_w  [5][NAX];
    logic signed [17:0] n_w0 [NAX];
    logic [30:0]        r_z2 [4][NAX];
    logic [30:0]        n_z20 [NAX];
    logic signed [31:0] r_p  [4][NAX];
    logic signed [31:0] n_p  [4][NAX];
    logic signed [31:0] r_y  [NAX];
    logic signed [31:0] n_y  [NAX];
    logic [15:0]        r_f  [NAX];
    logic [15:0]        n_f  [NAX];
    logic [15:0]        r_f1d, r_f2d, r_f2dd;
    logic [15:0]        r_m0, r_m1, r_m2, r_mask;
    logic [15:0]        n_m1, n_m2, n_mask;
    t_car               r_car [PIPE_N];
    logic [PIPE_N-1:0]  r_vld;
    logic               r_strobe;
    t_out               r_res;
    t_out               n_res;

    assign o_pop    = i_vld;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // divider: u = round((ex << 16) / taper), one quotient bit per stage
    always_comb begin
        logic [DIST_W+16:0] num;
        t_dstep init;
        for (int a = 0; a < NAX; a++) begin
            num       = {i_item.ex[a], 16'b0} + (DIST_W+17)'(i_taper >> 1);
            init.rem  = num[DIST_W+16:Q_W];
            init.low  = num[Q_W-1:0];
            init.q    = '0;
            n_ds[0][a] = div_step(init, i_taper);
            for (int k = 1; k < DIV_N; k++) begin
                n_ds[k][a] = div_step(r_ds[k-1][a], i_taper);
            end
        end
    end

    // raised cosine as (1 - sin(pi/2 z)) / 2, odd polynomial in Q30
    always_comb begin
        logic [Q_W-1:0]     u;
        logic signed [35:0] sq;
        logic signed [31:0] pin;
        logic signed [63:0] prod;
        logic signed [49:0] yp;
        logic signed [33:0] v;
        logic signed [33:0] vr;
        for (int a = 0; a < NAX; a++) begin
            u        = (r_ds[DIV_N-1][a].q > U_MAX) ? U_MAX : r_ds[DIV_N-1][a].q;
            n_w0[a]  = 18'($signed({1'b0, u, 1'b0}) - 19'sd65536);
            sq       = n_w0[a] * n_w0[a];
            n_z20[a] = sq[32:2];
            for (int j = 0; j < 4; j++) begin
                pin       = (j == 0) ? SIN_C9 : r_p[(j == 0) ? 0 : j-1][a];
                prod      = pin * $signed({1'b0, r_z2[j][a]});
                n_p[j][a] = COEF[j] + 32'(prod >>> 30);
            end
            yp      = r_w[4][a] * r_p[3][a];
            n_y[a]  = 32'(yp >>> 16);
            v       = 34'sh40000000 - 34'(r_y[a]);
            vr      = (v + 34'sd32768) >>> 16;
            if (v <= 0) begin
                n_f[a] = '0;
            end else if (vr > 34'sd32768) begin
                n_f[a] = ONE_Q15;
            end else begin
                n_f[a] = vr[15:0];
            end
        end
    end

    // axis factors multiplied in, then class and invert
    always_comb begin
        logic [31:0] mp;
        logic [31:0] mq;
        logic [15:0] mk;
        mp   = r_m0 * r_f1d + 32'd16384;
        n_m1 = r_car[24].act[1] ? mp[30:15] : r_m0;
        mq   = r_m1 * r_f2dd + 32'd16384;
        n_m2 = r_car[25].act[2] ? mq[30:15] : r_m1;
        unique case (r_car[26].cls)
            CLS_ZERO:  mk = '0;
            CLS_ONE:   mk = ONE_Q15;
            CLS_TAPER: mk = r_m2;
            default:   mk = '0;
        endcase
        n_mask = i_mode[MODE_INV_BIT] ? ONE_Q15 - mk : mk;
    end

    // sample scaling with round half up and saturation; mask mode outputs the mask instead
    always_comb begin
        logic signed [32:0] prod;
        logic signed [32:0] rnd;
        prod = r_car[PIPE_N-1].sample * $signed({1'b0, r_mask});
        rnd  = (prod + 33'sd16384) >>> 15;
        n_res.mask_value = r_mask;
        if (i_mode[MODE_MSK_BIT]) begin
            n_res.sample_out = (r_mask > 16'd32767) ? 16'sd32767 : $signed(r_mask);
        end else if (rnd > 33'sd32767) begin
            n_res.sample_out = 16'sd32767;
        end else if (rnd < -33'sd32768) begin
            n_res.sample_out = -16'sd32768;
        end else begin
            n_res.sample_out = rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[PIPE_N-2:0], i_vld};
            r_strobe <= r_vld[PIPE_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ds          <= n_ds;
        r_car[0].cls    <= i_item.cls;
        r_car[0].act    <= i_item.act;
        r_car[0].sample <= i_item.sample;
        for (int k = 1; k < PIPE_N; k++) begin
            r_car[k] <= r_car[k-1];
        end
        for (int a = 0; a < NAX; a++) begin
            r_w[0][a]  <= n_w0[a];
            r_z2[0][a] <= n_z20[a];
            for (int j = 1; j < 5; j++) begin
                r_w[j][a] <= r_w[j-1][a];
            end
            for (int j = 1; j < 4; j++) begin
                r_z2[j][a] <= r_z2[j-1][a];
            end
            for (int j = 0; j < 4; j++) begin
                r_p[j][a] <= n_p[j][a];
            end
            r_y[a] <= n_y[a];
            r_f[a] <= n_f[a];
        end
        r_m0   <= r_car[23].act[0] ? r_f[0] : ONE_Q15;
        r_f1d  <= r_f[1];
        r_f2d  <= r_f[2];
        r_f2dd <= r_f2d;
        r_m1   <= n_m1;
        r_m2   <= n_m2;
        r_mask <= n_mask;
        r_res  <= n_res;
    end

endmodule

// ----- rtl/rect_soft_mask_3d.sv -----
// Top level of the raised-cosine tapered box mask over 3-D voxels.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  request  | in        | i_start high, o_busy low    | i_item (z, y, x, sample)
//  result   | out       | o_strobe for one cycle      | o_result (sample, mask)
//  config   | in        | i_cfg_we high               | i_cfg_idx, i_cfg_data
//
// One request per clock, sustained. From the accepting edge to the result strobe
// lie one front register, one queue slot, 17 divider stages (one
// quotient bit each), 7 polynomial stages, 4 mask stages and the output register.
// o_busy is high during reset and in the clock after it; then it only rises if
// the queue backs up, which it cannot since the back end never stalls.
// Reset clears configuration (all zero) and empties the front register, queue and pipeline.
// Results cannot be held off: the receiver takes each strobe as it comes.
module rect_soft_mask_3d (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  rsm_pkg::t_in                   i_item,
    output logic                           o_strobe,
    output rsm_pkg::t_out                  o_result,
    input  logic                           i_cfg_we,
    input  logic [rsm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsm_pkg::CFG_W-1:0]      i_cfg_data
);
    import rsm_pkg::*;

    t_cfg  r_cfg;
    logic  push, full, q_vld, pop;
    t_item f_item, q_head;

    // register file; the user must write it only while no request is in flight, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_Z: r_cfg.center[0] <= i_cfg_data;
                REG_CENTER_Y: r_cfg.center[1] <= i_cfg_data;
                REG_CENTER_X: r_cfg.center[2] <= i_cfg_data;
                REG_RADIUS_Z: r_cfg.radius[0] <= i_cfg_data;
                REG_RADIUS_Y: r_cfg.radius[1] <= i_cfg_data;
                REG_RADIUS_X: r_cfg.radius[2] <= i_cfg_data;
                REG_TAPER:    r_cfg.taper     <= i_cfg_data;
                REG_MODE:     r_cfg.mode      <= i_cfg_data[1:0];
                default:      r_cfg.mode      <= r_cfg.mode;
            endcase
        end
    end

    // front: distances and inside / taper / outside classification
    rsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_busy  (o_busy),
        .o_push  (push),
        .o_item  (f_item)
    );

    // decouples front from back
    rsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_head  (q_head)
    );

    // back: per-axis taper factors, mask product, sample scaling
    rsm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .i_item   (q_head),
        .i_taper  (r_cfg.taper),
        .i_mode   (r_cfg.mode),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- rtl/rsm_checker.sv -----
// Port-level checks on the tapered box mask, bound to the top level.
`include "assert_macros.svh"

module rsm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_strobe,
    input rsm_pkg::t_out o_result
);
    import rsm_pkg::*;

    `RSM_ASSERT(a_res_has_req, i_clk, i_rst_n, o_strobe |-> $past(i_start && !o_busy, RESULT_LAT))
    `RSM_ASSERT(a_mask_range, i_clk, i_rst_n, o_strobe |-> o_result.mask_value <= ONE_Q15)
    `RSM_ASSERT(a_zero_mask, i_clk, i_rst_n, (o_strobe && o_result.mask_value == '0) |-> o_result.sample_out == '0)
    `RSM_ASSERT_ALWAYS(a_busy_rst, i_clk, !i_rst_n |=> o_busy)

endmodule

bind rect_soft_mask_3d rsm_checker u_rsm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- bench/rect_soft_mask_3d_tb.sv -----
// Self-checking bench for the tapered 3-D box mask: directed corners, then random voxels.
module rect_soft_mask_3d_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsm_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_in                  i_item;
    logic                 o_strobe;
    t_out                 o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    rect_soft_mask_3d u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Bench copy of the mask configuration
    logic [CFG_W-1:0] cfg_center [NAX];
    logic [CFG_W-1:0] cfg_radius [NAX];
    logic [CFG_W-1:0] cfg_taper;
    logic [1:0]       cfg_mode;

    t_out expected_masks [$];
    int   n_mismatch;
    bit   idle_on;

    // floor(v / 2^30) for signed 64-bit products
    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // raised-cosine falloff, Q1.15, for a band position u in Q16
    function automatic int unsigned falloff_q15(input int unsigned u);
        longint z, z2, p, v;
        z  = (longint'(u) * 2 - 65536) * 16384;
        z2 = q30_mul(z, z);
        p  = 172273;
        p  = -5026995 + q30_mul(p, z2);
        p  = 85569306 + q30_mul(p, z2);
        p  = -693598668 + q30_mul(p, z2);
        p  = 1686629713 + q30_mul(p, z2);
        v  = 64'sd1073741824 - q30_mul(z, p);
        if (v <= 0) return 0;
        v = (v + 32768) >>> 16;
        if (v > 32768) v = 32768;
        return int'(v);
    endfunction

    // Expected mask and output sample for one voxel
    function automatic t_out predict_voxel(input t_in vx);
        int unsigned axis_d [NAX];
        int unsigned crd    [NAX];
        int unsigned mask, u;
        longint      num, prod;
        bit          in_box, outside;
        t_out        res;
        crd[0] = vx.coord_z;
        crd[1] = vx.coord_y;
        crd[2] = vx.coord_x;
        in_box  = 1;
        outside = 0;
        for (int a = 0; a < NAX; a++) begin
            axis_d[a] = (crd[a] << 8) >= cfg_center[a] ? (crd[a] << 8) - cfg_center[a]
                                                       : cfg_center[a] - (crd[a] << 8);
            if (axis_d[a] > cfg_radius[a]) in_box = 0;
            if (longint'(axis_d[a]) > longint'(cfg_radius[a]) + cfg_taper) outside = 1;
        end
        if (cfg_taper == 0) mask = in_box ? 32768 : 0;
        else if (outside) mask = 0;
        else if (in_box) mask = 32768;
        else begin
            mask = 32768;
            for (int a = 0; a < NAX; a++) begin
                if (axis_d[a] > cfg_radius[a]) begin
                    num = longint'(axis_d[a] - cfg_radius[a]) << 16;
                    u   = int'((num + cfg_taper / 2) / cfg_taper);
                    if (u > 65536) u = 65536;
                    mask = (mask * falloff_q15(u) + 16384) >> 15;
                end
            end
        end
        if (cfg_mode[MODE_INV_BIT]) mask = 32768 - mask;
        if (cfg_mode[MODE_MSK_BIT]) prod = mask > 32767 ? 32767 : mask;
        else begin
            prod = (longint'(vx.sample_in) * longint'(mask) + 16384) >>> 15;
            if (prod > 32767) prod = 32767;
            if (prod < -32768) prod = -32768;
        end
        res.sample_out = prod[15:0];
        res.mask_value = mask[15:0];
        return res;
    endfunction

    // Result checker: outputs sampled at the rising edge
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_masks.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", o_result);
            end else begin
                want = expected_masks.pop_front();
                if (o_result.sample_out !== want.sample_out
                        || o_result.mask_value !== want.mask_value) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp sample %0d mask %0d, got sample %0d mask %0d",
                                 want.sample_out, want.mask_value,
                                 o_result.sample_out, o_result.mask_value);
                end
            end
        end
    end

    // Write enable stays high across a burst of writes; the caller drops it.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            REG_CENTER_Z: cfg_center[0] = val;
            REG_CENTER_Y: cfg_center[1] = val;
            REG_CENTER_X: cfg_center[2] = val;
            REG_RADIUS_Z: cfg_radius[0] = val;
            REG_RADIUS_Y: cfg_radius[1] = val;
            REG_RADIUS_X: cfg_radius[2] = val;
            REG_TAPER:    cfg_taper = val;
            REG_MODE:     cfg_mode = val[1:0];
            default: ;
        endcase
    endtask

    // Waits for the pipeline to drain, then a margin past its latency
    task automatic drain();
        i_start <= 1'b0;
        while (expected_masks.size() != 0) @(negedge i_clk);
        repeat (RESULT_LAT + 4) @(negedge i_clk);
    endtask

    task automatic load_box(input logic [CFG_W-1:0] cz, cy, cx, rz, ry, rx, tw,
                            input logic [1:0] md);
        drain();
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_RADIUS_Z, rz);
        write_reg(REG_RADIUS_Y, ry);
        write_reg(REG_RADIUS_X, rx);
        write_reg(REG_TAPER, tw);
        write_reg(REG_MODE, md);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one request, holding start until accepted; start stays high between
    // back-to-back requests and drops only when an idle gap follows.
    task automatic send_voxel(input t_in vx);
        int gap;
        i_item  <= vx;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_masks.push_back(predict_voxel(vx));
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic t_in rand_voxel_near(input int unsigned span);
        t_in vx;
        int unsigned c [NAX];
        for (int a = 0; a < NAX; a++) begin
            c[a] = (cfg_center[a] >> 8) + $urandom_range(0, 2 * span) - span;
            c[a] = c[a] & 12'hFFF;
        end
        vx.coord_z   = COORD_W'(c[0]);
        vx.coord_y   = COORD_W'(c[1]);
        vx.coord_x   = COORD_W'(c[2]);
        vx.sample_in = 16'($urandom());
        return vx;
    endfunction

    task automatic test_corners();
        t_in vx;
        load_box(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 2'd0);
        vx = '{12'd0, 12'd0, 12'd0, 16'sh7FFF};
        send_voxel(vx);
        vx = '{12'd0, 12'd0, 12'd0, 16'sh8000};
        send_voxel(vx);
        vx = '{12'hFFF, 12'hFFF, 12'hFFF, 16'sh8000};
        send_voxel(vx);
        // Hard box at the far corner, inverted
        load_box(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h00180, 20'h00180, 20'h00180, 20'd0, 2'd1);
        for (int k = 0; k < 5; k++) begin
            vx = '{COORD_W'(12'hFFF - k), 12'hFFF, 12'hFFE, 16'sh8000};
            send_voxel(vx);
        end
        // Soft box, every mode, samples at both extremes and -1
        for (int md = 0; md < 4; md++) begin
            load_box(20'h10000, 20'h10080, 20'h0FF80, 20'h00200, 20'h00100, 20'h00300,
                     20'h00400, md[1:0]);
            vx = '{12'h100, 12'h100, 12'h100, 16'sh7FFF};
            send_voxel(vx);
            vx = '{12'h103, 12'h101, 12'h0FC, 16'sh8000};
            send_voxel(vx);
            vx = '{12'h106, 12'h100, 12'h0F9, -16'sd1};
            send_voxel(vx);
            vx = '{12'h108, 12'h10A, 12'h100, 16'sh7FFF};
            send_voxel(vx);
        end
        // Largest taper and radius, smallest nonzero taper
        load_box(20'h80000, 20'h80000, 20'h80000, 20'hFFFFF, 20'd0, 20'd0, 20'hFFFFF, 2'd0);
        vx = '{12'h000, 12'h000, 12'hFFF, 16'sh4000};
        send_voxel(vx);
        load_box(20'h00080, 20'h00080, 20'h00080, 20'd0, 20'd0, 20'd0, 20'd1, 2'd0);
        vx = '{12'h000, 12'h001, 12'h000, 16'sh4000};
        send_voxel(vx);
    endtask

    task automatic test_random_boxes(input int n_items);
        int done;
        done = 0;
        while (done < n_items) begin
            load_box(CFG_W'($urandom_range(0, 20'hFFFFF)), CFG_W'($urandom_range(0, 20'hFFFFF)),
                     CFG_W'($urandom_range(0, 20'hFFFFF)), CFG_W'($urandom_range(0, 20'h3FFF)),
                     CFG_W'($urandom_range(0, 20'h3FFF)), CFG_W'($urandom_range(0, 20'h3FFF)),
                     CFG_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20'h3FFF)),
                     2'($urandom_range(0, 3)));
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 9) == 0) send_voxel(t_in'({$urandom(), $urandom()}));
                else send_voxel(rand_voxel_near(80));
            end
            done += 100;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_CENTER_Z;
        i_cfg_data = '0;
        n_mismatch = 0;
        idle_on    = 1'b1;
        cfg_taper  = '0;
        cfg_mode   = '0;
        for (int a = 0; a < NAX; a++) begin
            cfg_center[a] = '0;
            cfg_radius[a] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_corners();
        test_random_boxes(1000);
        // last stretch back to back, no idling
        idle_on = 1'b0;
        test_random_boxes(300);
        drain();
        if (n_mismatch == 0 && expected_masks.size() == 0) begin
            $display("rect_soft_mask_3d_tb passed");
        end else begin
            $display("rect_soft_mask_3d_tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("rect_soft_mask_3d_tb failed");
        $finish;
    end
endmodule
